// ===== hw/rtl/atvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package atvs_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ANGLE_TABLE_LEN  = 24;
  localparam int CORDIC_W         = 48;
  localparam int ANGLE_W          = 26;
  localparam int ROOT_IN_W        = 48;
  localparam int ROOT_OUT_W       = ROOT_IN_W / 2;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic signed [15:0] DEG64_LIMIT = 16'sd11520;
  localparam logic signed [16:0] FOLD_LIMIT  = 17'sd5760;

  // atan(2^-i) in 2^-16 degree
  localparam logic [21:0] ATAN_TAB [ANGLE_TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7,
    22'd4, 22'd2, 22'd1, 22'd0
  };

  localparam logic [1:0] CFG_TILT_FS = 2'd0;
  localparam logic [1:0] CFG_VIB_FS  = 2'd1;
  localparam logic [1:0] CFG_SHOCK   = 2'd2;

  typedef enum logic {
    KIND_MEASURE,
    KIND_CALIBRATE
  } kind_t;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [13:0] tilt_percent;
    logic [13:0] vibration_level;
    logic        crash;
    logic        was_calibration;
  } out_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } work_item_t;

  typedef struct packed {
    logic [13:0] tilt_fs;
    logic [15:0] vib_fs;
    logic [15:0] shock;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DEN_GO,
    ST_DEN_WAIT,
    ST_ROLL_GO,
    ST_ROLL_WAIT,
    ST_PITCH_GO,
    ST_PITCH_WAIT,
    ST_CALIB,
    ST_FOLD,
    ST_TILT_SQ,
    ST_TILT_GO,
    ST_TILT_WAIT,
    ST_VIB_GO,
    ST_VIB_WAIT,
    ST_TSCALE,
    ST_TDIV_LOAD,
    ST_TDIV,
    ST_VSCALE,
    ST_VDIV_LOAD,
    ST_VDIV,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/atvs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atvs_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  atvs_pkg::in_item_t   in_data,
  input  wire                  push,
  output logic                 full,
  output atvs_pkg::work_item_t q_data,
  output logic                 q_valid,
  input  wire                  q_take
);
  import atvs_pkg::*;

  work_item_t mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push_ok, take_ok;
  work_item_t classified;

  assign full    = (count_r == 2'(QUEUE_DEPTH));
  assign q_valid = (count_r != 2'd0);
  assign q_data  = mem_r[rd_ptr_r];
  assign push_ok = push && !full;
  assign take_ok = q_take && q_valid;

  always_comb begin
    classified.kind = in_data.opcode ? KIND_CALIBRATE : KIND_MEASURE;
    classified.x    = in_data.accel_x;
    classified.y    = in_data.accel_y;
    classified.z    = in_data.accel_z;
  end

  always_comb begin
    wr_ptr_nxt = push_ok ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = take_ok ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push_ok) - 2'(take_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= classified;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/atvs_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atvs_root (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 go,
  input  wire [atvs_pkg::ROOT_IN_W-1:0]       arg,
  output logic                                busy,
  output logic [atvs_pkg::ROOT_OUT_W-1:0]     root
);
  import atvs_pkg::*;

  localparam int REM_W = ROOT_OUT_W + 2;
  localparam int CNT_W = $clog2(ROOT_OUT_W);

  logic [ROOT_IN_W-1:0]  src_r;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [ROOT_OUT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic [REM_W+1:0]      rem2, trial;

  assign busy = busy_r;
  assign root = root_r;

  // one result bit a cycle: bring down two bits, try subtracting 4r+1
  always_comb begin
    rem2  = {rem_r, src_r[ROOT_IN_W-1 -: 2]};
    trial = {2'b00, root_r, 2'b01};
    if (rem2 >= trial) begin
      rem_nxt  = REM_W'(rem2 - trial);
      root_nxt = {root_r[ROOT_OUT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = REM_W'(rem2);
      root_nxt = {root_r[ROOT_OUT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_OUT_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      src_r  <= arg;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      src_r  <= {src_r[ROOT_IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/atvs_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atvs_cordic (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                go,
  input  wire signed [23:0]  y_in,
  input  wire signed [23:0]  x_in,
  output logic               busy,
  output logic signed [15:0] angle
);
  import atvs_pkg::*;

  logic signed [CORDIC_W-1:0] cx_r, cy_r, dx, dy;
  logic signed [ANGLE_W-1:0]  cz_r, z0, step, rnd;
  logic [4:0]                 it_r;
  logic                       busy_r, zero_r;
  logic signed [24:0]         xe, ye, px, py;

  assign busy = busy_r;

  // bring the vector into the right half plane first
  always_comb begin
    xe = 25'(x_in);
    ye = 25'(y_in);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        z0 = ANGLE_W'(90 * 65536);
        px = ye;
        py = -xe;
      end else begin
        z0 = -ANGLE_W'(90 * 65536);
        px = -ye;
        py = xe;
      end
    end else begin
      z0 = '0;
      px = xe;
      py = ye;
    end
  end

  always_comb begin
    dx   = cy_r >>> it_r;
    dy   = cx_r >>> it_r;
    step = ANGLE_W'(ATAN_TAB[it_r]);
    rnd  = (cz_r + ANGLE_W'(512)) >>> 10;
    if (zero_r) begin
      angle = '0;
    end else if (rnd > ANGLE_W'(DEG64_LIMIT)) begin
      angle = DEG64_LIMIT;
    end else if (rnd < -ANGLE_W'(DEG64_LIMIT)) begin
      angle = -DEG64_LIMIT;
    end else begin
      angle = 16'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      it_r   <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      it_r   <= '0;
    end else if (busy_r) begin
      it_r <= it_r + 1'b1;
      if (it_r == 5'(ANGLE_ITERATIONS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cx_r   <= CORDIC_W'(px) <<< 20;
      cy_r   <= CORDIC_W'(py) <<< 20;
      cz_r   <= z0;
      zero_r <= (x_in == 0) && (y_in == 0);
    end else if (busy_r) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + step;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - step;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/atvs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atvs_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  atvs_pkg::work_item_t q_data,
  input  wire                  q_valid,
  output logic                 q_take,
  input  atvs_pkg::cfg_t       cfg,
  output atvs_pkg::out_item_t  out_data,
  output logic                 out_valid,
  input  wire                  out_take
);
  import atvs_pkg::*;

  back_state_t state_r, state_nxt;

  kind_t              kind_r;
  logic signed [15:0] x_r, y_r, z_r;
  logic signed [15:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [15:0] base_roll_r, base_pitch_r;
  logic signed [15:0] roll_r, pitch_r, roll_f_r, pitch_d_r;
  logic [31:0]        yz_r, all_r;
  logic [34:0]        mag2_r;
  logic [30:0]        tilt2_r;
  logic               crash_r;
  logic [23:0]        den_r;
  logic [15:0]        tilt_root_r;
  logic [16:0]        mag_root_r;
  logic [13:0]        tilt_q_r;
  logic [2:0]         cnt_r;
  logic [3:0]         dcnt_r;
  logic signed [35:0] p_r;
  logic [16:0]        div_rem_r;
  logic [13:0]        div_low_r;
  logic [15:0]        div_d_r;
  out_item_t          res_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic signed [17:0] mul_a, mul_b;
  logic signed [16:0] dx, dy, dz, roll_diff, pitch_diff, roll_f1, roll_f2;
  logic [13:0]        tfs_eff;
  logic [15:0]        vfs_eff;
  logic [15:0]        tilt_min;
  logic [16:0]        mag_min;
  logic [16:0]        div_t, div_rem_nxt;
  logic [13:0]        div_low_nxt;
  logic               div_ge;
  logic               out_free;

  logic                  root_go, root_busy;
  logic [ROOT_IN_W-1:0]  root_arg;
  logic [ROOT_OUT_W-1:0] root_val;
  logic                  cor_go, cor_busy;
  logic signed [23:0]    cor_y, cor_x;
  logic signed [15:0]    cor_angle;

  atvs_root u_root (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (root_go),
    .arg  (root_arg),
    .busy (root_busy),
    .root (root_val)
  );

  atvs_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cor_go),
    .y_in (cor_y),
    .x_in (cor_x),
    .busy (cor_busy),
    .angle(cor_angle)
  );

  assign out_data  = out_r;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_take;

  always_comb begin
    dx         = 17'(x_r) - 17'(prev_x_r);
    dy         = 17'(y_r) - 17'(prev_y_r);
    dz         = 17'(z_r) - 17'(prev_z_r);
    roll_diff  = 17'(roll_r) - 17'(base_roll_r);
    pitch_diff = 17'(pitch_r) - 17'(base_pitch_r);
    // fold roll about +90 then about -90 degrees
    roll_f1    = 17'((roll_diff > FOLD_LIMIT) ? (2 * FOLD_LIMIT - roll_diff) : roll_diff);
    roll_f2    = 17'((roll_f1 < -FOLD_LIMIT) ? (-2 * FOLD_LIMIT - roll_f1) : roll_f1);
    tfs_eff    = (cfg.tilt_fs == '0) ? 14'd1 : cfg.tilt_fs;
    vfs_eff    = (cfg.vib_fs == '0) ? 16'd1 : cfg.vib_fs;
    tilt_min   = (tilt_root_r > 16'(tfs_eff)) ? 16'(tfs_eff) : tilt_root_r;
    mag_min    = (mag_root_r > 17'(vfs_eff)) ? 17'(vfs_eff) : mag_root_r;
  end

  // restoring division, one quotient bit a cycle
  always_comb begin
    div_t       = {div_rem_r[15:0], div_low_r[13]};
    div_ge      = div_t >= {1'b0, div_d_r};
    div_rem_nxt = div_ge ? (div_t - {1'b0, div_d_r}) : div_t;
    div_low_nxt = {div_low_r[12:0], div_ge};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (q_valid) state_nxt = ST_SQUARE;
      ST_SQUARE:     if (cnt_r == 3'd7) state_nxt = ST_DEN_GO;
      ST_DEN_GO:     state_nxt = ST_DEN_WAIT;
      ST_DEN_WAIT:   if (!root_busy) state_nxt = ST_ROLL_GO;
      ST_ROLL_GO:    state_nxt = ST_ROLL_WAIT;
      ST_ROLL_WAIT:  if (!cor_busy) state_nxt = ST_PITCH_GO;
      ST_PITCH_GO:   state_nxt = ST_PITCH_WAIT;
      ST_PITCH_WAIT: begin
        if (!cor_busy) state_nxt = (kind_r == KIND_CALIBRATE) ? ST_CALIB : ST_FOLD;
      end
      ST_CALIB:      state_nxt = ST_EMIT;
      ST_FOLD:       state_nxt = ST_TILT_SQ;
      ST_TILT_SQ:    if (cnt_r == 3'd2) state_nxt = ST_TILT_GO;
      ST_TILT_GO:    state_nxt = ST_TILT_WAIT;
      ST_TILT_WAIT:  if (!root_busy) state_nxt = ST_VIB_GO;
      ST_VIB_GO:     state_nxt = ST_VIB_WAIT;
      ST_VIB_WAIT:   if (!root_busy) state_nxt = ST_TSCALE;
      ST_TSCALE:     state_nxt = ST_TDIV_LOAD;
      ST_TDIV_LOAD:  state_nxt = ST_TDIV;
      ST_TDIV:       if (dcnt_r == 4'd13) state_nxt = ST_VSCALE;
      ST_VSCALE:     state_nxt = ST_VDIV_LOAD;
      ST_VDIV_LOAD:  state_nxt = ST_VDIV;
      ST_VDIV:       if (dcnt_r == 4'd13) state_nxt = ST_EMIT;
      ST_EMIT:       if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take   = 1'b0;
    root_go  = 1'b0;
    root_arg = '0;
    cor_go   = 1'b0;
    cor_y    = 24'(y_r);
    cor_x    = 24'(z_r);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      ST_IDLE:     q_take = q_valid;
      ST_SQUARE: begin
        case (cnt_r)
          3'd0: begin mul_a = 18'(y_r); mul_b = 18'(y_r); end
          3'd1: begin mul_a = 18'(z_r); mul_b = 18'(z_r); end
          3'd2: begin mul_a = 18'(x_r); mul_b = 18'(x_r); end
          3'd3: begin mul_a = 18'(dx); mul_b = 18'(dx); end
          3'd4: begin mul_a = 18'(dy); mul_b = 18'(dy); end
          3'd5: begin mul_a = 18'(dz); mul_b = 18'(dz); end
          3'd6: begin mul_a = {2'b00, cfg.shock}; mul_b = {2'b00, cfg.shock}; end
          default: ;
        endcase
      end
      ST_DEN_GO: begin
        root_go  = 1'b1;
        root_arg = ROOT_IN_W'({yz_r, 14'd0});
      end
      ST_ROLL_GO:  cor_go = 1'b1;
      ST_PITCH_GO: begin
        cor_go = 1'b1;
        cor_y  = -(24'(x_r) <<< 7);
        cor_x  = den_r;
      end
      ST_TILT_SQ: begin
        case (cnt_r)
          3'd0: begin mul_a = 18'(roll_f_r); mul_b = 18'(roll_f_r); end
          3'd1: begin mul_a = 18'(pitch_d_r); mul_b = 18'(pitch_d_r); end
          default: ;
        endcase
      end
      ST_TILT_GO: begin
        root_go  = 1'b1;
        root_arg = ROOT_IN_W'(tilt2_r);
      end
      ST_VIB_GO: begin
        root_go  = 1'b1;
        root_arg = ROOT_IN_W'(mag2_r);
      end
      ST_TSCALE: begin
        mul_a = {2'b00, tilt_min};
        mul_b = 18'sd10000;
      end
      ST_VSCALE: begin
        mul_a = {1'b0, mag_min};
        mul_b = 18'sd10000;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_z_r     <= '0;
      base_roll_r  <= '0;
      base_pitch_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_CALIB) begin
        base_roll_r  <= roll_r;
        base_pitch_r <= pitch_r;
      end
      if (state_r == ST_VIB_WAIT && !root_busy) begin
        prev_x_r <= x_r;
        prev_y_r <= y_r;
        prev_z_r <= z_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    case (state_r) inside
      ST_IDLE: begin
        kind_r <= q_data.kind;
        x_r    <= q_data.x;
        y_r    <= q_data.y;
        z_r    <= q_data.z;
        cnt_r  <= '0;
      end
      ST_SQUARE: begin
        cnt_r <= cnt_r + 1'b1;
        case (cnt_r) inside
          3'd1:       yz_r   <= p_r[31:0];
          3'd2:       yz_r   <= yz_r + p_r[31:0];
          3'd3:       all_r  <= p_r[31:0];
          3'd4:       mag2_r <= p_r[34:0];
          3'd5, 3'd6: mag2_r <= mag2_r + p_r[34:0];
          3'd7:       crash_r <= ({1'b0, all_r} + {1'b0, yz_r}) > p_r[32:0];
          default: ;
        endcase
      end
      ST_DEN_WAIT:   if (!root_busy) den_r <= root_val;
      ST_ROLL_WAIT:  if (!cor_busy) roll_r <= cor_angle;
      ST_PITCH_WAIT: if (!cor_busy) pitch_r <= cor_angle;
      ST_CALIB:      res_r <= '{tilt_percent: '0, vibration_level: '0,
                                crash: 1'b0, was_calibration: 1'b1};
      ST_FOLD: begin
        roll_f_r  <= 16'(roll_f2);
        pitch_d_r <= 16'(pitch_diff);
        cnt_r     <= '0;
      end
      ST_TILT_SQ: begin
        cnt_r <= cnt_r + 1'b1;
        case (cnt_r)
          3'd1:    tilt2_r <= p_r[30:0];
          3'd2:    tilt2_r <= tilt2_r + p_r[30:0];
          default: ;
        endcase
      end
      ST_TILT_WAIT:  if (!root_busy) tilt_root_r <= root_val[15:0];
      ST_VIB_WAIT:   if (!root_busy) mag_root_r <= root_val[16:0];
      ST_TDIV_LOAD, ST_VDIV_LOAD: begin
        div_rem_r <= {1'b0, p_r[29:14]};
        div_low_r <= p_r[13:0];
        div_d_r   <= (state_r == ST_TDIV_LOAD) ? 16'(tfs_eff) : vfs_eff;
        dcnt_r    <= '0;
      end
      ST_TDIV, ST_VDIV: begin
        div_rem_r <= div_rem_nxt;
        div_low_r <= div_low_nxt;
        dcnt_r    <= dcnt_r + 1'b1;
        if (dcnt_r == 4'd13) begin
          if (state_r == ST_TDIV) begin
            tilt_q_r <= div_low_nxt;
          end else begin
            res_r <= '{tilt_percent: tilt_q_r, vibration_level: div_low_nxt,
                       crash: crash_r, was_calibration: 1'b0};
          end
        end
      end
      // hold the waiting beat until the result register is free
      ST_EMIT:       if (out_free) out_r <= res_r;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/accel_tilt_vibration_shock_monitor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Accelerometer tilt, vibration and shock monitor.
// Input queue: drive in_data and raise push; a beat is taken when push is
// high and full is low. The front holds up to two samples, so the source
// can run ahead of the arithmetic.
// Result queue: while empty is low, out_data holds the oldest result; pop
// takes it. The result register holds while pop is low, and the back end
// finishes its next item and waits only at the final hand-off.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Write only while no item is in flight.
// Scheduling: one item is worked at a time; the back end takes no new item
// until the last one has been handed off. A measure item uses the shared
// square-root unit for three roots, the CORDIC for two angles and two
// divisions; a calibrate item uses one root and the two angles.
// Reset (rst_n low, synchronous) empties both queues, restores the default
// full scales and threshold, and clears baselines and the previous sample.
module accel_tilt_vibration_shock_monitor_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  atvs_pkg::in_item_t  in_data,
  input  wire                 push,
  output logic                full,
  output atvs_pkg::out_item_t out_data,
  output logic                empty,
  input  wire                 pop,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [1:0]           cfg_index,
  input  wire [15:0]          cfg_data
);
  import atvs_pkg::*;

  cfg_t       cfg_r;
  work_item_t q_data;
  logic       q_valid, q_take, out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tilt_fs <= 14'd5760;
      cfg_r.vib_fs  <= 16'd2048;
      cfg_r.shock   <= 16'd6144;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TILT_FS: cfg_r.tilt_fs <= cfg_data[13:0];
        CFG_VIB_FS:  cfg_r.vib_fs  <= cfg_data;
        CFG_SHOCK:   cfg_r.shock   <= cfg_data;
        default: ;
      endcase
    end
  end

  atvs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_data(in_data),
    .push   (push),
    .full   (full),
    .q_data (q_data),
    .q_valid(q_valid),
    .q_take (q_take)
  );

  atvs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_data),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .cfg      (cfg_r),
    .out_data (out_data),
    .out_valid(out_valid),
    .out_take (pop)
  );

  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.tilt_percent <= 14'd10000 &&
                out_data.vibration_level <= 14'd10000))
    else $error("result level above full scale");

  a_calib_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.was_calibration) |->
      (out_data.tilt_percent == '0 && out_data.vibration_level == '0 && !out_data.crash))
    else $error("calibration beat carries measurement fields");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result changed");

endmodule
`default_nettype wire
